// ===== rtl/ssdg_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper step/dir generator package
// Shared constants, types and helper functions of the step/dir generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdg_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned DIST_W      = 32;
  localparam int unsigned STEPS_W     = 31;
  localparam int unsigned SPEED_W     = 20;
  localparam int unsigned MODE_REQ_W  = 8;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned TIME_W      = 20;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned S_TDATA_W   = 64;
  localparam int unsigned M_TDATA_W   = 8;

  localparam logic [SPEED_W-1:0] USEC_PER_SEC = SPEED_W'(1000000);
  localparam int unsigned        MODE_COUNT   = 6;
  localparam int unsigned        DIV_STEPS    = SPEED_W;
  localparam int unsigned        DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0]  PULSE_HIGH_RESET = CFG_W'(4);
  localparam logic [CFG_W-1:0]  DEADBAND_RESET   = CFG_W'(4);
  localparam logic [MODE_W-1:0] MODE_RESET       = MODE_W'(0);

  localparam logic [MODE_W-1:0] MODE_PIN_TABLE [MODE_COUNT] = '{
    MODE_W'(0), MODE_W'(1), MODE_W'(2), MODE_W'(3), MODE_W'(4), MODE_W'(5)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_HIGH   = 2'd0,
    REG_DEADBAND     = 2'd1,
    REG_DEFAULT_MODE = 2'd2
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [MODE_REQ_W-1:0] mode;
    logic [SPEED_W-1:0]    speed;
    logic [DIST_W-1:0]     distance;
  } queue_entry_t;

  typedef struct packed {
    logic enqueue;
    logic tick_accept;
    logic load_start;
    logic div_step;
    logic low_calc;
    logic pulse;
    logic emit;
  } ssdg_cmd_t;

  typedef struct packed {
    logic phase_idle;
    logic queue_empty;
    logic div_last;
    logic out_free;
  } ssdg_status_t;

  // Returns {fixed, index}: an out-of-range mode selects mode 0 and flags it.
  function automatic logic [MODE_W:0] mode_apply_f(logic [MODE_REQ_W-1:0] m);
    logic [MODE_W:0] res;
    if (m >= MODE_REQ_W'(MODE_COUNT)) begin
      res = {1'b1, MODE_W'(0)};
    end else begin
      res = {1'b0, m[MODE_W-1:0]};
    end
    return res;
  endfunction

  function automatic logic [MODE_W-1:0] mode_pins_f(logic [MODE_W-1:0] idx);
    logic [MODE_W-1:0] res;
    if (idx < MODE_W'(MODE_COUNT)) begin
      res = MODE_PIN_TABLE[idx];
    end else begin
      res = MODE_PIN_TABLE[0];
    end
    return res;
  endfunction

  function automatic logic [QIDX_W-1:0] qidx_next_f(logic [QIDX_W-1:0] i);
    logic [QIDX_W-1:0] res;
    if (i == QIDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = i + QIDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ssdg_div.sv =====
// ----------------------------------------------------------------------------
// Period divider
// Restoring divider that computes one million divided by the speed, one
// quotient bit per cycle while step_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdg_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ssdg_pkg::SPEED_W-1:0] divisor_i,
  input  wire logic                        step_i,
  output logic      [ssdg_pkg::SPEED_W-1:0] quotient_o,
  output logic                             last_o
);

  logic [ssdg_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ssdg_pkg::SPEED_W-1:0]   rem_q, rem_d;
  logic [ssdg_pkg::SPEED_W-1:0]   quo_q, quo_d;
  logic [ssdg_pkg::SPEED_W-1:0]   div_q;
  logic [ssdg_pkg::SPEED_W:0]     trial;
  logic                           ge;

  always_comb begin
    trial = {rem_q, quo_q[ssdg_pkg::SPEED_W-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? ssdg_pkg::SPEED_W'(trial - {1'b0, div_q})
               : trial[ssdg_pkg::SPEED_W-1:0];
    quo_d = {quo_q[ssdg_pkg::SPEED_W-2:0], ge};
    cnt_d = cnt_q + ssdg_pkg::DIV_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= ssdg_pkg::USEC_PER_SEC;
      div_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = cnt_q == ssdg_pkg::DIV_CNT_W'(ssdg_pkg::DIV_STEPS - 1);

endmodule

`default_nettype wire

// ===== rtl/ssdg_datapath.sv =====
// ----------------------------------------------------------------------------
// Step/dir datapath
// Configuration registers, command queue, pulse timing state and the output
// word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdg_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ssdg_pkg::ssdg_cmd_t             cmd_i,
  output ssdg_pkg::ssdg_status_t               status_o,
  input  wire logic [ssdg_pkg::S_TDATA_W-1:0]  in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [ssdg_pkg::M_TDATA_W-1:0]  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ssdg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ssdg_pkg::CFG_W-1:0]      cfg_wdata_i
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

  logic [ssdg_pkg::CFG_W-1:0]   pht_q, db_q;
  logic                         any_loaded_q;
  logic [ssdg_pkg::MODE_W-1:0]  mode_idx_q;
  logic                         mode_fixed_q;

  ssdg_pkg::queue_entry_t       q_mem [ssdg_pkg::QUEUE_DEPTH];
  logic [ssdg_pkg::QIDX_W-1:0]  head_q, tail_q;
  logic [ssdg_pkg::QCNT_W-1:0]  count_q;
  logic                         q_full;

  logic                         dir_q;
  logic [ssdg_pkg::STEPS_W-1:0] steps_q;
  logic [ssdg_pkg::TIME_W-1:0]  low_q, timer_q;
  phase_e                       phase_q;
  logic                         step_lvl_q, accepted_q;
  logic                         out_valid_q;
  logic [ssdg_pkg::M_TDATA_W-1:0] out_data_q;

  logic [ssdg_pkg::DIST_W-1:0]    in_dist, in_mag, enq_dist;
  ssdg_pkg::queue_entry_t         head_entry;
  logic [ssdg_pkg::DIST_W-1:0]    neg_dist;
  logic [ssdg_pkg::STEPS_W-1:0]   load_steps;
  logic [ssdg_pkg::SPEED_W-1:0]   speed_eff, quotient;
  logic [ssdg_pkg::MODE_W:0]      load_mode, cfg_mode;
  logic [ssdg_pkg::TIME_W-1:0]    pht_ext, low_d;
  logic                           div_last;

  phase_e                         pl_phase;
  logic [ssdg_pkg::TIME_W-1:0]    pl_timer;
  logic [ssdg_pkg::STEPS_W-1:0]   pl_steps;
  logic                           pl_level;
  logic                           moving;

  always_comb begin
    in_dist  = in_data_i[ssdg_pkg::DIST_W-1:0];
    in_mag   = in_dist[ssdg_pkg::DIST_W-1] ? ssdg_pkg::DIST_W'(-in_dist) : in_dist;
    enq_dist = (in_mag < ssdg_pkg::DIST_W'(db_q)) ? '0 : in_dist;
    q_full   = count_q == ssdg_pkg::QCNT_W'(ssdg_pkg::QUEUE_DEPTH);

    head_entry = q_mem[head_q];
    neg_dist   = ssdg_pkg::DIST_W'(-head_entry.distance);
    if (!head_entry.distance[ssdg_pkg::DIST_W-1]) begin
      load_steps = head_entry.distance[ssdg_pkg::STEPS_W-1:0];
    end else if (head_entry.distance == {1'b1, {(ssdg_pkg::DIST_W-1){1'b0}}}) begin
      load_steps = '1;
    end else begin
      load_steps = neg_dist[ssdg_pkg::STEPS_W-1:0];
    end
    speed_eff = (head_entry.speed == '0) ? ssdg_pkg::SPEED_W'(1) : head_entry.speed;
    load_mode = ssdg_pkg::mode_apply_f(head_entry.mode);
    cfg_mode  = ssdg_pkg::mode_apply_f(ssdg_pkg::MODE_REQ_W'(cfg_wdata_i[ssdg_pkg::MODE_W-1:0]));

    pht_ext = ssdg_pkg::TIME_W'(pht_q);
    low_d   = (quotient < pht_ext) ? pht_ext : quotient - pht_ext;
  end

  ssdg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load_start),
    .divisor_i  (speed_eff),
    .step_i     (cmd_i.div_step),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  always_comb begin
    pl_phase = phase_q;
    pl_timer = timer_q;
    pl_steps = steps_q;
    pl_level = 1'b0;
    if (pl_phase == PH_IDLE && pl_steps != '0) begin
      pl_steps = pl_steps - ssdg_pkg::STEPS_W'(1);
      pl_phase = PH_HIGH;
      pl_timer = (pht_q == '0) ? ssdg_pkg::TIME_W'(1) : pht_ext;
    end
    case (pl_phase)
      PH_HIGH: begin
        pl_level = 1'b1;
        if (pl_timer != '0) begin
          pl_timer = pl_timer - ssdg_pkg::TIME_W'(1);
        end
        if (pl_timer == '0) begin
          if (low_q == '0) begin
            pl_phase = PH_IDLE;
          end else begin
            pl_phase = PH_LOW;
            pl_timer = low_q;
          end
        end
      end
      PH_LOW: begin
        if (pl_timer != '0) begin
          pl_timer = pl_timer - ssdg_pkg::TIME_W'(1);
        end
        if (pl_timer == '0) begin
          pl_phase = PH_IDLE;
        end
      end
      default: begin
        pl_phase = PH_IDLE;
        pl_timer = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pht_q        <= ssdg_pkg::PULSE_HIGH_RESET;
      db_q         <= ssdg_pkg::DEADBAND_RESET;
      any_loaded_q <= 1'b0;
      mode_idx_q   <= ssdg_pkg::MODE_RESET;
      mode_fixed_q <= 1'b0;
    end else if (cmd_i.load_start) begin
      any_loaded_q <= 1'b1;
      mode_idx_q   <= load_mode[ssdg_pkg::MODE_W-1:0];
      mode_fixed_q <= load_mode[ssdg_pkg::MODE_W];
    end else if (cfg_we_i) begin
      case (ssdg_pkg::cfg_reg_e'(cfg_idx_i))
        ssdg_pkg::REG_PULSE_HIGH: pht_q <= cfg_wdata_i;
        ssdg_pkg::REG_DEADBAND:   db_q  <= cfg_wdata_i;
        ssdg_pkg::REG_DEFAULT_MODE: begin
          if (!any_loaded_q) begin
            mode_idx_q   <= cfg_mode[ssdg_pkg::MODE_W-1:0];
            mode_fixed_q <= cfg_mode[ssdg_pkg::MODE_W];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.enqueue && !q_full) begin
      tail_q  <= ssdg_pkg::qidx_next_f(tail_q);
      count_q <= count_q + ssdg_pkg::QCNT_W'(1);
    end else if (cmd_i.load_start) begin
      head_q  <= ssdg_pkg::qidx_next_f(head_q);
      count_q <= count_q - ssdg_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enqueue && !q_full) begin
      q_mem[tail_q] <= '{
        mode:     in_data_i[ssdg_pkg::DIST_W+ssdg_pkg::SPEED_W +: ssdg_pkg::MODE_REQ_W],
        speed:    in_data_i[ssdg_pkg::DIST_W +: ssdg_pkg::SPEED_W],
        distance: enq_dist
      };
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= 1'b1;
      steps_q    <= '0;
      low_q      <= '0;
      timer_q    <= '0;
      phase_q    <= PH_IDLE;
      step_lvl_q <= 1'b0;
      accepted_q <= 1'b0;
    end else begin
      if (cmd_i.enqueue) begin
        accepted_q <= !q_full;
        step_lvl_q <= phase_q == PH_HIGH;
      end
      if (cmd_i.tick_accept) begin
        accepted_q <= 1'b0;
      end
      if (cmd_i.load_start) begin
        dir_q   <= !head_entry.distance[ssdg_pkg::DIST_W-1];
        steps_q <= load_steps;
      end
      if (cmd_i.low_calc) begin
        low_q <= low_d;
      end
      if (cmd_i.pulse) begin
        phase_q    <= pl_phase;
        timer_q    <= pl_timer;
        steps_q    <= pl_steps;
        step_lvl_q <= pl_level;
      end
    end
  end

  assign moving = (steps_q != '0) || (phase_q != PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {mode_fixed_q, moving, accepted_q,
                     ssdg_pkg::mode_pins_f(mode_idx_q), dir_q, step_lvl_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o = '{
    phase_idle:  phase_q == PH_IDLE,
    queue_empty: count_q == '0,
    div_last:    div_last,
    out_free:    !out_valid_q || out_ready_i
  };

endmodule

`default_nettype wire

// ===== rtl/ssdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Step/dir controller
// Sequences move words through queueing and result output, and tick
// words through command load and division if due, pulse and output.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdg_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   in_opcode_i,
  input  wire ssdg_pkg::ssdg_status_t status_i,
  output ssdg_pkg::ssdg_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_LOWT  = 5'b00100,
    ST_PULSE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (ssdg_pkg::opcode_e'(in_opcode_i) == ssdg_pkg::OP_MOVE) begin
            cmd_o.enqueue = 1'b1;
            state_d       = ST_EMIT;
          end else begin
            cmd_o.tick_accept = 1'b1;
            if (status_i.phase_idle && !status_i.queue_empty) begin
              cmd_o.load_start = 1'b1;
              state_d          = ST_DIV;
            end else begin
              state_d = ST_PULSE;
            end
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_LOWT;
        end
      end
      ST_LOWT: begin
        cmd_o.low_calc = 1'b1;
        state_d        = ST_PULSE;
      end
      ST_PULSE: begin
        cmd_o.pulse = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

`default_nettype wire

// ===== rtl/stepper_step_dir_generator.sv =====
// With the output free, a move word goes from acceptance through the emit state to its
// result word. A tick word passes the pulse and emit states; one that loads a command
// first passes the divide state, where the period divider makes one bit per cycle, and
// the low-time state. No new word is taken until the last one's result word is emitted.
// Reset is asynchronous and active low; it empties the queue, idles the pulse, sets
// the direction bit high and restores the register defaults.
// ----------------------------------------------------------------------------
// Stepper step/dir generator
// Queues move commands and turns one-microsecond tick words into step,
// direction and microstep mode pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_step_dir_generator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // distance [31:0], speed [51:32], mode_request [59:52], zero [63:60]
  input  wire logic [ssdg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // opcode [0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // step_pin [0], dir_pin [1], mode_pins [4:2], accepted [5], moving [6],
  // mode_fixed [7]
  output logic      [ssdg_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                            cfg_we_i,
  input  wire logic [ssdg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ssdg_pkg::CFG_W-1:0]      cfg_wdata_i
);

  ssdg_pkg::ssdg_cmd_t    cmd;
  ssdg_pkg::ssdg_status_t status;

  ssdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ssdg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

`default_nettype wire

// ===== rtl/ssdg_checker.sv =====
// ----------------------------------------------------------------------------
// Step/dir generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdg_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_tvalid_i,
  input wire logic                           s_tready_i,
  input wire logic                           m_tvalid_i,
  input wire logic                           m_tready_i,
  input wire logic [ssdg_pkg::M_TDATA_W-1:0] m_tdata_i
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("Output word dropped while stalled.");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i))
    else $error("Output word changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("Input taken while a word is still in work.");

  a_mode_pins_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[4:2] != 3'd6 && m_tdata_i[4:2] != 3'd7))
    else $error("Mode pins show an unsupported mode.");

  a_fixed_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[7] |-> m_tdata_i[4:2] == 3'd0)
    else $error("Forced mode is not full step.");

endmodule

bind stepper_step_dir_generator ssdg_checker u_ssdg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

`default_nettype wire
